/* sv/slms_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slms_pkg: shared types and constants of the seat lock motor sequencer
// Seat and supply state codes, command codes, register indexes, the
// configuration and state bundles and their reset values.
// ----------------------------------------------------------------------------
package slms_pkg;

  localparam int unsigned TICK_W = 8;

  typedef enum logic [1:0] {
    CMD_TICK_50MS = 2'd0,
    CMD_TICK_1S   = 2'd1,
    CMD_SEAT_REQ  = 2'd2,
    CMD_MECH_REQ  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_LOCKED    = 3'd0,
    ST_WAIT      = 3'd1,
    ST_UNLOCKING = 3'd2,
    ST_UNLOCKED  = 3'd3,
    ST_LOCKING   = 3'd4,
    ST_OVERUSE   = 3'd5
  } lock_state_t;

  typedef enum logic [1:0] {
    SUP_BLOCK   = 2'd0,
    SUP_POWERED = 2'd1,
    SUP_ACTED   = 2'd2
  } supply_state_t;

  typedef enum logic [1:0] {
    MECH_NONE   = 2'd0,
    MECH_LOCK   = 2'd1,
    MECH_UNLOCK = 2'd2
  } mech_t;

  typedef enum logic [2:0] {
    REG_UNLOCK_DRIVE  = 3'd0,
    REG_LOCK_DRIVE    = 3'd1,
    REG_UNLOCKED_HOLD = 3'd2,
    REG_POWERON_DELAY = 3'd3,
    REG_UNLOCK_WINDOW = 3'd4,
    REG_UNLOCK_LIMIT  = 3'd5
  } reg_index_t;

  // target bits
  localparam int unsigned TB_SEAT      = 0;
  localparam int unsigned TB_SEAT_LOCK = 1;
  localparam int unsigned TB_MECH      = 2;
  localparam int unsigned TB_MECH_LOCK = 3;

  // pin level bits
  localparam int unsigned PIN_SUPPLY = 0;
  localparam int unsigned PIN_A1     = 1;
  localparam int unsigned PIN_A2     = 2;

  localparam logic [TICK_W-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic [TICK_W-1:0] unlock_drive_ticks;
    logic [TICK_W-1:0] lock_drive_ticks;
    logic [TICK_W-1:0] unlocked_hold_ticks;
    logic [TICK_W-1:0] poweron_delay_ticks;
    logic [TICK_W-1:0] unlock_window_seconds;
    logic [TICK_W-1:0] unlock_limit;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    unlock_drive_ticks:    8'd10,
    lock_drive_ticks:      8'd10,
    unlocked_hold_ticks:   8'd100,
    poweron_delay_ticks:   8'd2,
    unlock_window_seconds: 8'd60,
    unlock_limit:          8'd5
  };

  typedef struct packed {
    lock_state_t       lock_state;
    logic [TICK_W-1:0] action_timer;
    logic [TICK_W-1:0] unlock_count;
    logic [TICK_W-1:0] window_timer;
    logic              request_pending;
    supply_state_t     supply_state;
    logic [TICK_W-1:0] supply_timer;
    logic [3:0]        target_bits;
    logic [2:0]        pin_levels;
  } state_t;

  localparam state_t STATE_RESET = '{
    lock_state:      ST_LOCKED,
    action_timer:    '0,
    unlock_count:    '0,
    window_timer:    '0,
    request_pending: 1'b0,
    supply_state:    SUP_BLOCK,
    supply_timer:    '0,
    target_bits:     '0,
    pin_levels:      '0
  };

  typedef struct packed {
    mech_t       mech_action;
    logic        notify;
    logic        motor_a2;
    logic        motor_a1;
    logic        supply_on;
    lock_state_t seat_status;
  } result_t;

endpackage

/* sv/slms_cfg_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slms_cfg_regs: configuration register file
// Six 8-bit timing and limit registers; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module slms_cfg_regs (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic [2:0]         wr_index,
  input  logic [7:0]         wr_data,
  output slms_pkg::cfg_t     cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= slms_pkg::CFG_RESET;
    end else if (wr_en) begin
      case (wr_index)
        slms_pkg::REG_UNLOCK_DRIVE:  cfg.unlock_drive_ticks    <= wr_data;
        slms_pkg::REG_LOCK_DRIVE:    cfg.lock_drive_ticks      <= wr_data;
        slms_pkg::REG_UNLOCKED_HOLD: cfg.unlocked_hold_ticks   <= wr_data;
        slms_pkg::REG_POWERON_DELAY: cfg.poweron_delay_ticks   <= wr_data;
        slms_pkg::REG_UNLOCK_WINDOW: cfg.unlock_window_seconds <= wr_data;
        slms_pkg::REG_UNLOCK_LIMIT:  cfg.unlock_limit          <= wr_data;
        default: begin
        end
      endcase
    end
  end

endmodule

/* sv/slms_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slms_step: next-state and result logic for one item
// Seat machine first, then the supply sequencer, on a 50 ms tick.
// ----------------------------------------------------------------------------
module slms_step (
  input  slms_pkg::state_t  cur,
  input  slms_pkg::cfg_t    cfg,
  input  slms_pkg::cmd_t    cmd,
  input  logic              stopped,
  input  logic              mdir,
  output slms_pkg::state_t  nxt,
  output slms_pkg::result_t res
);

  slms_pkg::state_t s;
  logic             notify;
  slms_pkg::mech_t  mech;

  always_comb begin
    s      = cur;
    notify = 1'b0;
    mech   = slms_pkg::MECH_NONE;

    unique case (cmd)
      slms_pkg::CMD_TICK_50MS: begin
        // seat machine
        if (s.action_timer != '0) s.action_timer = s.action_timer - 8'd1;
        case (s.lock_state)
          slms_pkg::ST_LOCKED: begin
            if (s.request_pending) begin
              s.lock_state      = slms_pkg::ST_WAIT;
              s.request_pending = 1'b0;
              notify            = 1'b1;
            end
          end
          slms_pkg::ST_WAIT: begin
            if (stopped) begin
              if (s.unlock_count <= cfg.unlock_limit) begin
                s.target_bits[slms_pkg::TB_SEAT]      = 1'b1;
                s.target_bits[slms_pkg::TB_SEAT_LOCK] = 1'b0;
              end else begin
                s.lock_state = slms_pkg::ST_OVERUSE;
                notify       = 1'b1;
              end
            end
          end
          slms_pkg::ST_UNLOCKING: begin
            if (s.action_timer == '0) begin
              s.pin_levels   = '0;
              s.lock_state   = slms_pkg::ST_UNLOCKED;
              s.action_timer = cfg.unlocked_hold_ticks;
              notify         = 1'b1;
            end
          end
          slms_pkg::ST_UNLOCKED: begin
            if (s.action_timer == '0) begin
              s.target_bits[slms_pkg::TB_SEAT]      = 1'b1;
              s.target_bits[slms_pkg::TB_SEAT_LOCK] = 1'b1;
            end
          end
          slms_pkg::ST_LOCKING: begin
            if (s.action_timer == '0) begin
              s.pin_levels = '0;
              s.lock_state = slms_pkg::ST_LOCKED;
              notify       = 1'b1;
            end
          end
          default: begin
          end
        endcase
        // every active state drops a latched request with a notification
        if (cur.lock_state != slms_pkg::ST_LOCKED && s.request_pending) begin
          s.request_pending = 1'b0;
          notify            = 1'b1;
        end

        // supply sequencer
        if (s.supply_timer != '0) s.supply_timer = s.supply_timer - 8'd1;
        case (s.supply_state)
          slms_pkg::SUP_BLOCK: begin
            if (s.target_bits != '0) begin
              s.pin_levels[slms_pkg::PIN_SUPPLY] = 1'b1;
              s.supply_timer = cfg.poweron_delay_ticks;
              s.supply_state = slms_pkg::SUP_POWERED;
            end
          end
          slms_pkg::SUP_POWERED: begin
            if (s.supply_timer == '0) begin
              if (s.target_bits[slms_pkg::TB_MECH]) begin
                mech = s.target_bits[slms_pkg::TB_MECH_LOCK] ?
                       slms_pkg::MECH_LOCK : slms_pkg::MECH_UNLOCK;
              end else if (s.target_bits[slms_pkg::TB_SEAT]) begin
                if (s.target_bits[slms_pkg::TB_SEAT_LOCK]) begin
                  s.pin_levels[slms_pkg::PIN_A1] = 1'b0;
                  s.pin_levels[slms_pkg::PIN_A2] = 1'b1;
                  s.action_timer = cfg.lock_drive_ticks;
                  s.lock_state   = slms_pkg::ST_LOCKING;
                end else begin
                  s.pin_levels[slms_pkg::PIN_A2] = 1'b0;
                  s.pin_levels[slms_pkg::PIN_A1] = 1'b1;
                  s.action_timer = cfg.unlock_drive_ticks;
                  s.lock_state   = slms_pkg::ST_UNLOCKING;
                  // saturating count, window opens on the first unlock
                  if (s.unlock_count != slms_pkg::COUNT_MAX) begin
                    s.unlock_count = s.unlock_count + 8'd1;
                  end
                  if (s.unlock_count == 8'd1) s.window_timer = cfg.unlock_window_seconds;
                end
              end
              s.supply_state = slms_pkg::SUP_ACTED;
            end
          end
          slms_pkg::SUP_ACTED: begin
            s.target_bits  = '0;
            s.supply_state = slms_pkg::SUP_BLOCK;
          end
          default: begin
          end
        endcase
      end
      slms_pkg::CMD_TICK_1S: begin
        if (s.window_timer != '0) begin
          s.window_timer = s.window_timer - 8'd1;
          if (s.window_timer == '0) begin
            s.unlock_count = '0;
            if (s.lock_state == slms_pkg::ST_OVERUSE) s.lock_state = slms_pkg::ST_LOCKED;
          end
        end
      end
      slms_pkg::CMD_SEAT_REQ: begin
        s.request_pending = 1'b1;
      end
      slms_pkg::CMD_MECH_REQ: begin
        s.target_bits[slms_pkg::TB_MECH]      = 1'b1;
        s.target_bits[slms_pkg::TB_MECH_LOCK] = mdir;
      end
    endcase
  end

  assign nxt             = s;
  assign res.seat_status = s.lock_state;
  assign res.supply_on   = s.pin_levels[slms_pkg::PIN_SUPPLY];
  assign res.motor_a1    = s.pin_levels[slms_pkg::PIN_A1];
  assign res.motor_a2    = s.pin_levels[slms_pkg::PIN_A2];
  assign res.notify      = notify;
  assign res.mech_action = mech;

endmodule

/* sv/seat_lock_motor_sequencer_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seat_lock_motor_sequencer_core: motor-driven seat lock controller
// Seat unlock sequencing with overuse lockout and a shared 9V supply
// sequencer that also passes out mechanical lock commands.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------
//  s_*     | in        | s_tvalid / s_tready  | tuser: command, tdata: flags
//  m_*     | out       | m_tvalid / m_tready  | tdata: status, pins, events
//  cfg_*   | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data (8 bit)
//
//  One item per cycle sustained while the result side is ready; each item
//  passes the input register, then the step logic, then the result register.
//  Synchronous reset restores the register defaults and the locked,
//  idle-supply state; neither input side is ready while it is high.
//  A stalled result register holds and backs up the input register; the input
//  side keeps taking items while either stage has room. Configuration writes
//  are ready whenever reset is low and take effect at once.
//
module seat_lock_motor_sequencer_core (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [0] hall_stopped, [1] mech_lock_dir, [7:2] zero
  input  logic [1:0]  s_tuser,   // [1:0] command
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [2:0] seat_status, [3] supply_on, [4] motor_a1,
                                 // [5] motor_a2, [6] notify, [8:7] mech_action,
                                 // [15:9] zero
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam int unsigned RES_W = $bits(slms_pkg::result_t);

  slms_pkg::cfg_t    cfg;
  slms_pkg::state_t  state;
  slms_pkg::state_t  state_next;
  slms_pkg::result_t res_next;

  logic              in_valid;
  slms_pkg::cmd_t    in_cmd;
  logic              in_stopped;
  logic              in_mdir;
  logic              advance;

  // Config port never stalls outside reset.
  assign cfg_ready = !rst;

  slms_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // The result register is free when empty or being drained this cycle.
  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !rst && (!in_valid || advance);

  // Input register: load on a transfer, drop once handed to the step logic.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_cmd     <= slms_pkg::cmd_t'(s_tuser);
      in_stopped <= s_tdata[0];
      in_mdir    <= s_tdata[1];
    end
  end

  slms_step u_step (
    .cur     (state),
    .cfg     (cfg),
    .cmd     (in_cmd),
    .stopped (in_stopped),
    .mdir    (in_mdir),
    .nxt     (state_next),
    .res     (res_next)
  );

  // Commit the state and capture the result when the item leaves the input
  // register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= slms_pkg::STATE_RESET;
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid;
      if (in_valid) state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      m_tdata <= {{(16 - RES_W){1'b0}}, res_next};
    end
  end

endmodule

/* bench/seat_lock_motor_sequencer_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seat_lock_motor_sequencer_core_tb: self-checking bench for the seat lock core
// Drives tick, seat request and mechanical request transfers into the core,
// predicts every status result with a cycle-free model of the seat machine
// and the 9V supply sequencer, and checks each result transfer field by field.
// Both stream sides idle at random; timing registers change between phases.
// ----------------------------------------------------------------------------
module seat_lock_motor_sequencer_core_tb;
  import slms_pkg::*;

  localparam int unsigned TIMEOUT_NS = 5_000_000;
  localparam int unsigned MAX_REPORTS = 60;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [7:0]  cfg_data;

  // Model of the core: timing registers and seat / supply state
  cfg_t    timing_regs;
  state_t  seat_model;
  result_t expected_status_q[$];
  int unsigned mismatch_count;

  // When clear, that side runs back to back with no idle cycles
  bit tx_gaps_on;
  bit rx_gaps_on;

  seat_lock_motor_sequencer_core DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Test completed with failures");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Status prediction. Advance the model by one accepted item and return the
  // status the core must report for it. On a 50 ms tick the seat machine runs
  // first, then the supply sequencer.
  // --------------------------------------------------------------------------
  function automatic result_t predict_seat_result(cmd_t cmd, logic stopped, logic mdir);
    result_t r;
    logic    notify_now;
    mech_t   mech_now;
    notify_now = 1'b0;
    mech_now   = MECH_NONE;
    case (cmd)
      CMD_TICK_50MS: begin
        if (seat_model.action_timer != '0)
          seat_model.action_timer = seat_model.action_timer - 8'd1;
        case (seat_model.lock_state)
          ST_LOCKED: begin
            if (seat_model.request_pending)
              seat_model.lock_state = ST_WAIT;
          end
          ST_WAIT: begin
            // Wheel stopped: either ask the supply for an unlock or lock out
            if (stopped) begin
              if (seat_model.unlock_count <= timing_regs.unlock_limit) begin
                seat_model.target_bits[TB_SEAT]      = 1'b1;
                seat_model.target_bits[TB_SEAT_LOCK] = 1'b0;
              end else begin
                seat_model.lock_state = ST_OVERUSE;
                notify_now = 1'b1;
              end
            end
          end
          ST_UNLOCKING: begin
            if (seat_model.action_timer == '0) begin
              seat_model.pin_levels   = '0;
              seat_model.lock_state   = ST_UNLOCKED;
              seat_model.action_timer = timing_regs.unlocked_hold_ticks;
              notify_now = 1'b1;
            end
          end
          ST_UNLOCKED: begin
            if (seat_model.action_timer == '0) begin
              seat_model.target_bits[TB_SEAT]      = 1'b1;
              seat_model.target_bits[TB_SEAT_LOCK] = 1'b1;
            end
          end
          ST_LOCKING: begin
            if (seat_model.action_timer == '0) begin
              seat_model.pin_levels = '0;
              seat_model.lock_state = ST_LOCKED;
              notify_now = 1'b1;
            end
          end
          default: ;
        endcase
        // A latched seat request is consumed by the tick in every seat state
        if (seat_model.request_pending) begin
          seat_model.request_pending = 1'b0;
          notify_now = 1'b1;
        end

        if (seat_model.supply_timer != '0)
          seat_model.supply_timer = seat_model.supply_timer - 8'd1;
        case (seat_model.supply_state)
          SUP_BLOCK: begin
            if (seat_model.target_bits != '0) begin
              seat_model.pin_levels[PIN_SUPPLY] = 1'b1;
              seat_model.supply_timer = timing_regs.poweron_delay_ticks;
              seat_model.supply_state = SUP_POWERED;
            end
          end
          SUP_POWERED: begin
            if (seat_model.supply_timer == '0) begin
              // Mechanical target wins; supply pin is left as it is
              if (seat_model.target_bits[TB_MECH]) begin
                mech_now = seat_model.target_bits[TB_MECH_LOCK] ? MECH_LOCK : MECH_UNLOCK;
              end else if (seat_model.target_bits[TB_SEAT]) begin
                if (seat_model.target_bits[TB_SEAT_LOCK]) begin
                  seat_model.pin_levels[PIN_A1] = 1'b0;
                  seat_model.pin_levels[PIN_A2] = 1'b1;
                  seat_model.action_timer = timing_regs.lock_drive_ticks;
                  seat_model.lock_state   = ST_LOCKING;
                end else begin
                  seat_model.pin_levels[PIN_A2] = 1'b0;
                  seat_model.pin_levels[PIN_A1] = 1'b1;
                  seat_model.action_timer = timing_regs.unlock_drive_ticks;
                  seat_model.lock_state   = ST_UNLOCKING;
                  if (seat_model.unlock_count != COUNT_MAX)
                    seat_model.unlock_count = seat_model.unlock_count + 8'd1;
                  if (seat_model.unlock_count == 8'd1)
                    seat_model.window_timer = timing_regs.unlock_window_seconds;
                end
              end
              seat_model.supply_state = SUP_ACTED;
            end
          end
          SUP_ACTED: begin
            seat_model.target_bits  = '0;
            seat_model.supply_state = SUP_BLOCK;
          end
          default: ;
        endcase
      end
      CMD_TICK_1S: begin
        // Window expiry clears the count and releases an overuse lock silently
        if (seat_model.window_timer != '0) begin
          seat_model.window_timer = seat_model.window_timer - 8'd1;
          if (seat_model.window_timer == '0) begin
            seat_model.unlock_count = '0;
            if (seat_model.lock_state == ST_OVERUSE)
              seat_model.lock_state = ST_LOCKED;
          end
        end
      end
      CMD_SEAT_REQ: seat_model.request_pending = 1'b1;
      default: begin
        seat_model.target_bits[TB_MECH]      = 1'b1;
        seat_model.target_bits[TB_MECH_LOCK] = mdir;
      end
    endcase
    r.seat_status = seat_model.lock_state;
    r.supply_on   = seat_model.pin_levels[PIN_SUPPLY];
    r.motor_a1    = seat_model.pin_levels[PIN_A1];
    r.motor_a2    = seat_model.pin_levels[PIN_A2];
    r.notify      = notify_now;
    r.mech_action = mech_now;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Input side: idle a random number of cycles, then hold the transfer until
  // the core takes it. Valid stays high when the next item follows at once.
  // --------------------------------------------------------------------------
  task automatic send_seat_item(cmd_t cmd, logic stopped, logic mdir);
    int unsigned gap;
    if ($urandom_range(0, 39) == 0)
      tx_gaps_on = !tx_gaps_on;
    gap = tx_gaps_on ? $urandom_range(0, 9) : 0;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {6'd0, mdir, stopped};
    do @(posedge clk); while (!s_tready);
    expected_status_q.push_back(predict_seat_result(cmd, stopped, mdir));
  endtask

  // Drop valid and wait until every predicted status has come back
  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (expected_status_q.size() != 0);
  endtask

  // Write all six timing registers while the core is idle
  task automatic load_timing_registers(cfg_t regs);
    reg_index_t idx;
    logic [7:0] value;
    drain_results();
    cfg_valid <= 1'b1;
    for (int i = REG_UNLOCK_DRIVE; i <= REG_UNLOCK_LIMIT; i++) begin
      idx = reg_index_t'(i);
      case (idx)
        REG_UNLOCK_DRIVE:  value = regs.unlock_drive_ticks;
        REG_LOCK_DRIVE:    value = regs.lock_drive_ticks;
        REG_UNLOCKED_HOLD: value = regs.unlocked_hold_ticks;
        REG_POWERON_DELAY: value = regs.poweron_delay_ticks;
        REG_UNLOCK_WINDOW: value = regs.unlock_window_seconds;
        default:           value = regs.unlock_limit;
      endcase
      cfg_index <= idx;
      cfg_data  <= value;
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    timing_regs = regs;
  endtask

  // Mostly 50 ms ticks so sequences progress; requests and 1 s ticks mixed in
  task automatic run_random_traffic(int unsigned count, int unsigned tick_pct);
    int unsigned roll;
    cmd_t cmd;
    for (int unsigned n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < tick_pct)
        cmd = CMD_TICK_50MS;
      else if (roll < tick_pct + (100 - tick_pct) * 4 / 10)
        cmd = CMD_TICK_1S;
      else if (roll < tick_pct + (100 - tick_pct) * 7 / 10)
        cmd = CMD_SEAT_REQ;
      else
        cmd = CMD_MECH_REQ;
      send_seat_item(cmd, $urandom_range(0, 3) != 0, 1'($urandom_range(0, 1)));
    end
  endtask

  // --------------------------------------------------------------------------
  // Test tasks
  // --------------------------------------------------------------------------

  // Reset register values: mechanical commands both ways, mechanical priority
  // over a seat target, request consumption, a full unlock start
  task automatic test_directed_sequence();
    send_seat_item(CMD_TICK_1S,   1'b0, 1'b0);  // window idle, nothing moves
    send_seat_item(CMD_MECH_REQ,  1'b1, 1'b1);  // mechanical lock target
    repeat (4) send_seat_item(CMD_TICK_50MS, 1'b1, 1'b1);
    send_seat_item(CMD_MECH_REQ,  1'b0, 1'b0);  // mechanical unlock target
    send_seat_item(CMD_SEAT_REQ,  1'b0, 1'b1);  // latched only, no notify
    send_seat_item(CMD_TICK_50MS, 1'b0, 1'b0);  // consume request, wait stop
    repeat (3) send_seat_item(CMD_TICK_50MS, 1'b1, 1'b0);
    repeat (3) send_seat_item(CMD_TICK_50MS, 1'b1, 1'b0);  // seat unlock drive
    send_seat_item(CMD_SEAT_REQ,  1'b1, 1'b1);  // request while unlocking
    send_seat_item(CMD_TICK_50MS, 1'b1, 1'b1);
    send_seat_item(CMD_MECH_REQ,  1'b1, 1'b1);
    send_seat_item(CMD_TICK_1S,   1'b1, 1'b1);  // window counting down
    repeat (3) send_seat_item(CMD_TICK_50MS, 1'b0, 1'b1);
  endtask

  // All timers zero, tight window, no unlock allowed past the first
  task automatic test_zero_timers_overuse();
    load_timing_registers('{unlock_drive_ticks: 8'd0, lock_drive_ticks: 8'd0,
                            unlocked_hold_ticks: 8'd0, poweron_delay_ticks: 8'd0,
                            unlock_window_seconds: 8'd3, unlock_limit: 8'd0});
    run_random_traffic(250, 60);
  endtask

  // Short random timing; pause mid-way until every result has come back
  task automatic test_short_random_timing();
    load_timing_registers('{unlock_drive_ticks: 8'($urandom_range(1, 6)),
                            lock_drive_ticks: 8'($urandom_range(1, 6)),
                            unlocked_hold_ticks: 8'($urandom_range(0, 8)),
                            poweron_delay_ticks: 8'($urandom_range(1, 4)),
                            unlock_window_seconds: 8'($urandom_range(2, 20)),
                            unlock_limit: 8'($urandom_range(1, 4))});
    run_random_traffic(200, 60);
    drain_results();
    run_random_traffic(200, 60);
  endtask

  // Register maxima: long drives, then long hold and power-on delay; widest window, limit 254
  task automatic test_register_maxima();
    load_timing_registers('{unlock_drive_ticks: 8'd255, lock_drive_ticks: 8'd255,
                            unlocked_hold_ticks: 8'd0, poweron_delay_ticks: 8'd0,
                            unlock_window_seconds: 8'd255, unlock_limit: 8'd254});
    run_random_traffic(150, 85);
    load_timing_registers('{unlock_drive_ticks: 8'd1, lock_drive_ticks: 8'd1,
                            unlocked_hold_ticks: 8'd255, poweron_delay_ticks: 8'd255,
                            unlock_window_seconds: 8'd255, unlock_limit: 8'd254});
    run_random_traffic(150, 85);
  endtask

  // Zero window never expires, so the count only grows; keep this phase last
  task automatic test_window_disabled();
    load_timing_registers('{unlock_drive_ticks: 8'd1, lock_drive_ticks: 8'd2,
                            unlocked_hold_ticks: 8'd1, poweron_delay_ticks: 8'd1,
                            unlock_window_seconds: 8'd0, unlock_limit: 8'd2});
    run_random_traffic(120, 65);
  endtask

  // --------------------------------------------------------------------------
  // Result side: stall at random, check each transfer against the oldest
  // prediction
  // --------------------------------------------------------------------------
  task automatic report_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
    end
  endtask

  initial begin : result_checker
    result_t got;
    result_t want;
    int unsigned stall;
    m_tready <= 1'b0;
    @(negedge rst);
    forever begin
      if ($urandom_range(0, 39) == 0)
        rx_gaps_on = !rx_gaps_on;
      stall = rx_gaps_on ? $urandom_range(0, 9) : 0;
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      got = result_t'(m_tdata[8:0]);
      if (expected_status_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t: result transfer with none expected, actual %h", $time, m_tdata);
      end else begin
        want = expected_status_q.pop_front();
        report_field("seat_status", want.seat_status, got.seat_status);
        report_field("supply_on",   want.supply_on,   got.supply_on);
        report_field("motor_a1",    want.motor_a1,    got.motor_a1);
        report_field("motor_a2",    want.motor_a2,    got.motor_a2);
        report_field("notify",      want.notify,      got.notify);
        report_field("mech_action", want.mech_action, got.mech_action);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    s_tvalid   <= 1'b0;
    s_tdata    <= '0;
    s_tuser    <= CMD_TICK_50MS;
    cfg_valid  <= 1'b0;
    cfg_index  <= REG_UNLOCK_DRIVE;
    cfg_data   <= '0;
    timing_regs    = CFG_RESET;
    seat_model     = STATE_RESET;
    mismatch_count = 0;
    tx_gaps_on     = 1'b1;
    rx_gaps_on     = 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_directed_sequence();
    test_zero_timers_overuse();
    test_short_random_timing();
    test_register_maxima();
    test_window_disabled();

    drain_results();
    repeat (4) @(posedge clk);  // let any stray result surface
    if (mismatch_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

/* filelist.f */
sv/slms_pkg.sv
sv/slms_cfg_regs.sv
sv/slms_step.sv
sv/seat_lock_motor_sequencer_core.sv
bench/seat_lock_motor_sequencer_core_tb.sv
